>>> rtl/bole_pkg.sv
// ---------------------------------------------------------------------------
// bole_pkg
// Shared constants, codes and types of the bounded ordered list engine.
// ---------------------------------------------------------------------------
package bole_pkg;

    // list capacity and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int STAT_W   = 2;
    // compare width for position against entry count
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_MAX       = 3'd6;
    localparam logic [CMD_W-1:0] CMD_MIN       = 3'd7;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    // flags from the shared compare unit
    typedef struct packed {
        logic eq;
        logic lt;
        logic gt;
    } cmp_t;

    // logical list offset to ring buffer address
    function automatic logic [IDX_W-1:0] phys_addr(
        input logic [IDX_W-1:0] head,
        input logic [CNT_W-1:0] ofs
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(ofs);
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

>>> rtl/bole_ram.sv
// ---------------------------------------------------------------------------
// bole_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module bole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bole_alu.sv
// ---------------------------------------------------------------------------
// bole_alu
// Shared signed compare unit used by lookup, max and min scans.
// ---------------------------------------------------------------------------
module bole_alu (
    input  logic signed [bole_pkg::DATA_W-1:0] a,
    input  logic signed [bole_pkg::DATA_W-1:0] b,
    output bole_pkg::cmp_t                     res
);
    import bole_pkg::*;

    // signed compare of stored word against reference
    always_comb
    begin
        res.eq = (a == b);
        res.lt = (a < b);
        res.gt = (a > b);
    end

endmodule

>>> rtl/bole_seq.sv
// ---------------------------------------------------------------------------
// bole_seq
// Command sequencer: ring buffer pointers, scan and shift walks, results.
// ---------------------------------------------------------------------------
module bole_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bole_pkg::CMD_W-1:0]          command,
    input  logic signed [bole_pkg::DATA_W-1:0]  value,
    input  logic [bole_pkg::POS_W-1:0]          position,
    output logic                                done,
    output logic                                found,
    output logic signed [bole_pkg::DATA_W-1:0]  extreme,
    output logic [bole_pkg::COUNT_W-1:0]        count,
    output logic [bole_pkg::STAT_W-1:0]         status,
    output logic                                ram_we,
    output logic [bole_pkg::IDX_W-1:0]          ram_waddr,
    output logic [bole_pkg::DATA_W-1:0]         ram_wdata,
    output logic [bole_pkg::IDX_W-1:0]          ram_raddr,
    input  logic [bole_pkg::DATA_W-1:0]         ram_rdata,
    output logic signed [bole_pkg::DATA_W-1:0]  alu_a,
    output logic signed [bole_pkg::DATA_W-1:0]  alu_b,
    input  bole_pkg::cmp_t                      alu_res
);
    import bole_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_SHIFT
    } state_t;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CMD_W-1:0]          cmd_reg, cmd_next;
    logic signed [DATA_W-1:0]  value_reg, value_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          wr_idx_reg, wr_idx_next;
    logic                      issue_reg, issue_next;
    logic                      rd_valid_reg, rd_valid_next;
    logic signed [DATA_W-1:0]  acc_reg, acc_next;
    logic                      seeded_reg, seeded_next;
    logic                      found_reg, found_next;
    logic [STAT_W-1:0]         status_reg, status_next;
    logic                      done_reg, done_next;

    logic                      full;
    logic                      empty;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          cnt_ext;
    logic [CNT_W-1:0]          pos_cnt;
    logic [IDX_W-1:0]          head_dec;
    logic [IDX_W-1:0]          head_inc;

    // occupancy and insert position, zero position acts as one
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_ext = (pos_reg == '0) ? CMP_W'(1) : CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_cnt = pos_ext[CNT_W-1:0];

    // head pointer moves with wrap
    assign head_dec = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - IDX_W'(1);
    assign head_inc = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + IDX_W'(1);

    // compare operands: searched value for lookup, running extreme otherwise
    assign alu_a = ram_rdata;
    assign alu_b = (cmd_reg == CMD_LOOKUP) ? value_reg : acc_reg;

    // next state and memory access
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        cmd_next      = cmd_reg;
        value_next    = value_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        wr_idx_next   = wr_idx_reg;
        issue_next    = issue_reg;
        rd_valid_next = 1'b0;
        acc_next      = acc_reg;
        seeded_next   = seeded_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        done_next     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = phys_addr(head_reg, count_reg);
        ram_wdata     = value_reg;
        ram_raddr     = phys_addr(head_reg, idx_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = command;
                    value_next  = value;
                    pos_next    = position;
                    acc_next    = '0;
                    seeded_next = (command != CMD_MIN);
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    idx_next    = '0;
                    state_next  = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (cmd_reg)
                    CMD_PUSH_HEAD:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = head_dec;
                            head_next  = head_dec;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_PUSH_TAIL:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_POP_HEAD:
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            head_next  = head_inc;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    CMD_POP_TAIL:
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (pos_ext > cnt_ext)
                        begin
                            status_next = ST_BADPOS;
                        end
                        else if (pos_ext == cnt_ext)
                        begin
                            // insert after last entry is a tail append
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            // open a gap: walk from the tail down to the position
                            done_next  = 1'b0;
                            idx_next   = count_reg - CNT_W'(1);
                            issue_next = 1'b1;
                            state_next = S_SHIFT;
                        end
                    end
                    default:
                    begin
                        done_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                endcase
            end

            S_SCAN:
            begin
                // fold the word read last cycle
                if (rd_valid_reg)
                begin
                    case (cmd_reg)
                        CMD_LOOKUP:
                        begin
                            if (alu_res.eq)
                            begin
                                found_next = 1'b1;
                            end
                        end
                        CMD_MAX:
                        begin
                            if (alu_res.gt)
                            begin
                                acc_next = ram_rdata;
                            end
                        end
                        default:
                        begin
                            if (!seeded_reg || alu_res.lt)
                            begin
                                acc_next    = ram_rdata;
                                seeded_next = 1'b1;
                            end
                        end
                    endcase
                end
                // issue the next read, or finish once drained
                if (idx_reg != count_reg)
                begin
                    rd_valid_next = 1'b1;
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else if (!rd_valid_reg)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end

            S_SHIFT:
            begin
                // move the word read last cycle one place toward the tail
                if (rd_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = phys_addr(head_reg, wr_idx_reg);
                    ram_wdata = ram_rdata;
                end
                if (issue_reg)
                begin
                    rd_valid_next = 1'b1;
                    wr_idx_next   = idx_reg + CNT_W'(1);
                    if (idx_reg == pos_cnt)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - CNT_W'(1);
                    end
                end
                else if (!rd_valid_reg)
                begin
                    // gap is open: drop the new word in
                    ram_we     = 1'b1;
                    ram_waddr  = phys_addr(head_reg, pos_cnt);
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, pointers and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            acc_reg      <= '0;
            status_reg   <= ST_OK;
            seeded_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
            acc_reg      <= acc_next;
            status_reg   <= status_next;
            seeded_reg   <= seeded_next;
        end
    end

    // command payload
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        wr_idx_reg <= wr_idx_next;
    end

    // result word
    logic [CMP_W-1:0] count_wide;
    assign count_wide = CMP_W'(count_reg);

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign found   = found_reg;
    assign extreme = acc_reg;
    assign count   = count_wide[COUNT_W-1:0];
    assign status  = status_reg;

endmodule

>>> rtl/bounded_ordered_list_engine_top.sv
// ---------------------------------------------------------------------------
// bounded_ordered_list_engine_top
// Bounded deque of signed 32-bit words with positional insert and lookup, max and min queries.
// ---------------------------------------------------------------------------
// push, pop and refused commands: start is taken in idle, done is registered in the decide state
// lookup, max, min: a scan of every entry after the decide state, one entry read per cycle
// insert: walk from tail to position, position 0 counted as 1, one entry moved per cycle
// the single read port of the entry RAM sets the walk rate
// a new command is taken in the cycle done is high; results cannot stall
// reset empties the list at once, no clearing pass
// ---------------------------------------------------------------------------
module bounded_ordered_list_engine_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bole_pkg::CMD_W-1:0]          command,
    input  logic signed [bole_pkg::DATA_W-1:0]  value,
    input  logic [bole_pkg::POS_W-1:0]          position,
    output logic                                done,
    output logic                                found,
    output logic signed [bole_pkg::DATA_W-1:0]  extreme,
    output logic [bole_pkg::COUNT_W-1:0]        count,
    output logic [bole_pkg::STAT_W-1:0]         status
);
    import bole_pkg::*;

    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [DATA_W-1:0]         ram_wdata;
    logic [IDX_W-1:0]          ram_raddr;
    logic [DATA_W-1:0]         ram_rdata;
    logic signed [DATA_W-1:0]  alu_a;
    logic signed [DATA_W-1:0]  alu_b;
    cmp_t                      alu_res;

    // command sequencer
    bole_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .value     (value),
        .position  (position),
        .done      (done),
        .found     (found),
        .extreme   (extreme),
        .count     (count),
        .status    (status),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .alu_a     (alu_a),
        .alu_b     (alu_b),
        .alu_res   (alu_res)
    );

    // entry storage, ring buffer
    bole_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare unit
    bole_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

endmodule

>>> rtl/bole_checker.sv
// ---------------------------------------------------------------------------
// bole_checker
// Port-level checks of the list engine, bound to the top level.
// ---------------------------------------------------------------------------
module bole_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [bole_pkg::COUNT_W-1:0] count,
    input logic [bole_pkg::STAT_W-1:0]  status
);
    import bole_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

    // accepted word makes the engine busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepted word");

    // result word only when idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    // one result word per command
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word repeated");

    // full refusal leaves a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (count == FULL_COUNT))
        else $error("full refusal with list not full");

    // empty pop reports an empty list
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (count == '0))
        else $error("empty no-op with entries present");

endmodule

bind bounded_ordered_list_engine_top bole_checker u_bole_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .count  (count),
    .status (status)
);

>>> tb/sv/tb_bounded_ordered_list_engine_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_bounded_ordered_list_engine_top
// Checks the bounded ordered list engine word by word against a shadow copy
// of the list kept here. A directed table covers the empty and full list,
// value extremes and bad insert positions. Random words with fill and drain
// phases follow. Each returned word is compared with the oldest one awaited.
// ---------------------------------------------------------------------------
module tb_bounded_ordered_list_engine_top;

    import bole_pkg::*;

    // one result word of the engine
    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] extreme;
        logic [COUNT_W-1:0]       count;
        logic [STAT_W-1:0]        status;
    } list_reply_t;

    // one row of the directed table, reply used only when typed is set
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] word_value;
        logic [POS_W-1:0]         word_pos;
        logic [4:0]               reps;
        logic                     typed;
        list_reply_t              reply;
    } list_row_t;

    localparam int DIRECTED_ROWS = 27;
    localparam int RANDOM_WORDS  = 400;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [CMD_W-1:0]           command;
    logic signed [DATA_W-1:0]   value;
    logic [POS_W-1:0]           position;
    logic                       done;
    logic                       found;
    logic signed [DATA_W-1:0]   extreme;
    logic [COUNT_W-1:0]         count;
    logic [STAT_W-1:0]          status;

    // shadow list, head at index 0
    logic signed [DATA_W-1:0]   shadow_entries [CAPACITY];
    int                         shadow_count;
    list_reply_t                reply_queue [$];
    list_reply_t                oldest_reply;
    int                         mismatch_total;
    bit                         idle_enable;
    bit                         filling;

    // directed words: empty list, value extremes, positions, full list
    list_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_POP_HEAD,  32'sd0,        5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd0,  ST_EMPTY}},
        '{CMD_POP_TAIL,  32'sd0,        5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd0,  ST_EMPTY}},
        '{CMD_LOOKUP,    32'sd0,        5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd0,  ST_OK}},
        '{CMD_MAX,       32'sd0,        5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd0,  ST_OK}},
        '{CMD_MIN,       32'sd0,        5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd0,  ST_OK}},
        '{CMD_INSERT,    32'sd5,        5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd0,  ST_BADPOS}},
        '{CMD_PUSH_HEAD, -32'sd5,       5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd1,  ST_OK}},
        '{CMD_MAX,       32'sd0,        5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd1,  ST_OK}},
        '{CMD_MIN,       32'sd0,        5'd0,  5'd1,  1'b1, '{1'b0, -32'sd5, 5'd1, ST_OK}},
        '{CMD_PUSH_HEAD, 32'h7FFFFFFF,  5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd2,  ST_OK}},
        '{CMD_PUSH_TAIL, 32'h80000000,  5'd31, 5'd1,  1'b1, '{1'b0, 32'sd0, 5'd3,  ST_OK}},
        '{CMD_MAX,       32'sd0,        5'd0,  5'd1,  1'b1, '{1'b0, 32'h7FFFFFFF, 5'd3, ST_OK}},
        '{CMD_MIN,       32'sd0,        5'd0,  5'd1,  1'b1, '{1'b0, 32'h80000000, 5'd3, ST_OK}},
        '{CMD_LOOKUP,    32'h80000000,  5'd0,  5'd1,  1'b1, '{1'b1, 32'sd0, 5'd3,  ST_OK}},
        '{CMD_LOOKUP,    -32'sd1,       5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd3,  ST_OK}},
        '{CMD_INSERT,    -32'sd1,       5'd0,  5'd1,  1'b0, '0},
        '{CMD_INSERT,    32'sd42,       5'd4,  5'd1,  1'b0, '0},
        '{CMD_INSERT,    32'sd7,        5'd6,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd5,  ST_BADPOS}},
        '{CMD_INSERT,    32'sd7,        5'd31, 5'd1,  1'b1, '{1'b0, 32'sd0, 5'd5,  ST_BADPOS}},
        '{CMD_PUSH_TAIL, 32'sd123,      5'd0,  5'd11, 1'b0, '0},
        '{CMD_PUSH_HEAD, 32'sd9,        5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd16, ST_FULL}},
        '{CMD_INSERT,    32'sd9,        5'd31, 5'd1,  1'b1, '{1'b0, 32'sd0, 5'd16, ST_FULL}},
        '{CMD_INSERT,    32'sd9,        5'd1,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd16, ST_FULL}},
        '{CMD_LOOKUP,    32'sd123,      5'd0,  5'd1,  1'b1, '{1'b1, 32'sd0, 5'd16, ST_OK}},
        '{CMD_POP_HEAD,  32'sd0,        5'd0,  5'd1,  1'b0, '0},
        '{CMD_POP_TAIL,  32'sd0,        5'd0,  5'd15, 1'b0, '0},
        '{CMD_POP_HEAD,  32'sd0,        5'd0,  5'd1,  1'b1, '{1'b0, 32'sd0, 5'd0,  ST_EMPTY}}
    };

    bounded_ordered_list_engine_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .command  (command),
        .value    (value),
        .position (position),
        .done     (done),
        .found    (found),
        .extreme  (extreme),
        .count    (count),
        .status   (status)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one accepted word to the shadow list and return its result
    function automatic list_reply_t apply_list_command(
        input logic [CMD_W-1:0]         cmd,
        input logic signed [DATA_W-1:0] word_value,
        input logic [POS_W-1:0]         word_pos
    );
        list_reply_t              reply;
        int                       slot;
        int                       after;
        logic signed [DATA_W-1:0] top;
        reply = '0;
        case (cmd)
            CMD_PUSH_HEAD, CMD_PUSH_TAIL, CMD_INSERT:
            begin
                // insert slot, position 0 acts as 1
                if (cmd == CMD_PUSH_HEAD)
                begin
                    after = 0;
                end
                else if (cmd == CMD_PUSH_TAIL)
                begin
                    after = shadow_count;
                end
                else
                begin
                    after = (word_pos == '0) ? 1 : int'(word_pos);
                end
                if (shadow_count >= CAPACITY)
                begin
                    reply.status = ST_FULL;
                end
                else if (after > shadow_count)
                begin
                    reply.status = ST_BADPOS;
                end
                else
                begin
                    for (slot = shadow_count; slot > after; slot--)
                    begin
                        shadow_entries[slot] = shadow_entries[slot-1];
                    end
                    shadow_entries[after] = word_value;
                    shadow_count++;
                end
            end
            CMD_POP_HEAD:
            begin
                if (shadow_count == 0)
                begin
                    reply.status = ST_EMPTY;
                end
                else
                begin
                    for (slot = 0; slot < shadow_count - 1; slot++)
                    begin
                        shadow_entries[slot] = shadow_entries[slot+1];
                    end
                    shadow_count--;
                end
            end
            CMD_POP_TAIL:
            begin
                if (shadow_count == 0)
                begin
                    reply.status = ST_EMPTY;
                end
                else
                begin
                    shadow_count--;
                end
            end
            CMD_LOOKUP:
            begin
                for (slot = 0; slot < shadow_count; slot++)
                begin
                    if (shadow_entries[slot] == word_value)
                    begin
                        reply.found = 1'b1;
                    end
                end
            end
            default:
            begin
                // max search starts at 0, min search starts at that max
                top = '0;
                for (slot = 0; slot < shadow_count; slot++)
                begin
                    if (shadow_entries[slot] > top)
                    begin
                        top = shadow_entries[slot];
                    end
                end
                if (cmd == CMD_MIN)
                begin
                    for (slot = 0; slot < shadow_count; slot++)
                    begin
                        if (shadow_entries[slot] < top)
                        begin
                            top = shadow_entries[slot];
                        end
                    end
                end
                reply.extreme = top;
            end
        endcase
        reply.count = COUNT_W'(shadow_count);
        return reply;
    endfunction

    // command mix leans on pushes while filling and on pops while draining
    function automatic logic [CMD_W-1:0] pick_command(input bit grow);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            return CMD_W'($urandom_range(0, 7));
        end
        roll = $urandom_range(0, 99);
        if (grow)
        begin
            if (roll < 28) return CMD_PUSH_HEAD;
            if (roll < 48) return CMD_PUSH_TAIL;
            if (roll < 70) return CMD_INSERT;
            if (roll < 78) return CMD_POP_HEAD;
            if (roll < 84) return CMD_POP_TAIL;
            if (roll < 92) return CMD_LOOKUP;
            if (roll < 96) return CMD_MAX;
            return CMD_MIN;
        end
        if (roll < 30) return CMD_POP_HEAD;
        if (roll < 55) return CMD_POP_TAIL;
        if (roll < 62) return CMD_PUSH_HEAD;
        if (roll < 67) return CMD_PUSH_TAIL;
        if (roll < 72) return CMD_INSERT;
        if (roll < 86) return CMD_LOOKUP;
        if (roll < 93) return CMD_MAX;
        return CMD_MIN;
    endfunction

    // values: stored ones for lookup hits, a small pool for duplicates,
    // the signed extremes, and full random words
    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30 && shadow_count > 0)
        begin
            return shadow_entries[$urandom_range(0, shadow_count - 1)];
        end
        if (roll < 55)
        begin
            return DATA_W'(int'($urandom_range(0, 7)) - 4);
        end
        if (roll < 65)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFFFFFF;
                1: return 32'h80000000;
                2: return 32'h00000000;
                default: return 32'hFFFFFFFF;
            endcase
        end
        return $urandom();
    endfunction

    // send one word, wait for it to be taken, then log its result
    task automatic issue_word(
        input logic [CMD_W-1:0]         cmd,
        input logic signed [DATA_W-1:0] word_value,
        input logic [POS_W-1:0]         word_pos,
        input bit                       typed,
        input list_reply_t              typed_reply
    );
        list_reply_t shadow_reply;
        if (idle_enable && $urandom_range(0, 99) < 14)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        start    <= 1'b1;
        command  <= cmd;
        value    <= word_value;
        position <= word_pos;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        shadow_reply = apply_list_command(cmd, word_value, word_pos);
        reply_queue.push_back(typed ? typed_reply : shadow_reply);
    endtask

    task automatic drain_replies();
        while (reply_queue.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // compare each returned word with the oldest one awaited
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (reply_queue.size() == 0)
            begin
                $error("result word with none awaited: count %0d status %0d",
                       count, status);
                mismatch_total++;
            end
            else
            begin
                oldest_reply = reply_queue.pop_front();
                if (found !== oldest_reply.found)
                begin
                    $error("found: expected %0d, got %0d", oldest_reply.found, found);
                    mismatch_total++;
                end
                if (extreme !== oldest_reply.extreme)
                begin
                    $error("extreme: expected %0d, got %0d", oldest_reply.extreme, extreme);
                    mismatch_total++;
                end
                if (count !== oldest_reply.count)
                begin
                    $error("count: expected %0d, got %0d", oldest_reply.count, count);
                    mismatch_total++;
                end
                if (status !== oldest_reply.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_reply.status, status);
                    mismatch_total++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #3000000;
        $display("** bounded_ordered_list_engine_top: FAILED **");
        $finish;
    end

    initial
    begin
        int          row;
        int          rep;
        int          word_idx;
        int          settle;
        logic [POS_W-1:0] rand_pos;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        command        <= CMD_PUSH_HEAD;
        value          <= '0;
        position       <= '0;
        shadow_count   = 0;
        mismatch_total = 0;
        idle_enable    = 1'b1;
        filling        = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            for (rep = 0; rep < int'(directed_rows[row].reps); rep++)
            begin
                issue_word(directed_rows[row].cmd, directed_rows[row].word_value,
                           directed_rows[row].word_pos, directed_rows[row].typed,
                           directed_rows[row].reply);
            end
        end

        // hold off until the directed words are all back
        start <= 1'b0;
        drain_replies();

        // random words in fill and drain phases
        for (word_idx = 0; word_idx < RANDOM_WORDS; word_idx++)
        begin
            idle_enable = (word_idx < 150 || word_idx >= 270);
            if (filling && shadow_count == CAPACITY && $urandom_range(0, 3) == 0)
            begin
                filling = 1'b0;
            end
            else if (!filling && shadow_count == 0 && $urandom_range(0, 3) == 0)
            begin
                filling = 1'b1;
            end
            if (word_idx == 300)
            begin
                start <= 1'b0;
                drain_replies();
            end
            if ($urandom_range(0, 9) < 7)
            begin
                rand_pos = POS_W'($urandom_range(0, shadow_count + 1));
            end
            else
            begin
                rand_pos = POS_W'($urandom_range(0, 31));
            end
            issue_word(pick_command(filling), pick_value(), rand_pos, 1'b0, '0);
        end

        // wait for the last results, then keep watching for strays
        start <= 1'b0;
        settle = 0;
        while (reply_queue.size() != 0 && settle < 2000)
        begin
            @(posedge clk);
            settle++;
        end
        if (reply_queue.size() != 0)
        begin
            $error("%0d result words never arrived", reply_queue.size());
            mismatch_total++;
        end
        repeat (40) @(posedge clk);

        if (mismatch_total == 0)
        begin
            $display("** bounded_ordered_list_engine_top: PASSED **");
        end
        else
        begin
            $display("** bounded_ordered_list_engine_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/bole_pkg.sv
rtl/bole_ram.sv
rtl/bole_alu.sv
rtl/bole_seq.sv
rtl/bounded_ordered_list_engine_top.sv
rtl/bole_checker.sv
tb/sv/tb_bounded_ordered_list_engine_top.sv
